@@ hdl/cmmr_pkg.sv @@
// ----------------------------------------------------------------------------
// cmmr_pkg
// Shared constants, register codes and controller/datapath command and status
// types of the cluster-map mode resampler.
// ----------------------------------------------------------------------------
package cmmr_pkg;

  localparam int NUM_STATES = 14;
  localparam int MAX_SOURCE = 1048576;
  localparam int MAX_TARGET = 8192;

  localparam int STATE_W   = 4;
  localparam int SRC_W     = 21;
  localparam int TGT_W     = 14;
  localparam int CFG_W     = SRC_W;
  localparam int CFG_IDX_W = 1;

  localparam int SIDX_W    = $clog2(MAX_SOURCE);
  localparam int TIDX_W    = $clog2(MAX_TARGET);
  localparam int TALLY_W   = SRC_W;
  localparam int FILL_W    = SRC_W;
  localparam int DIV_W     = SRC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int MEM_AW    = $clog2(NUM_STATES);
  localparam int SCAN_W    = $clog2(NUM_STATES + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_COUNT,
    REG_TARGET_COUNT
  } cfg_reg_e;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic div_start;
    logic div_step;
    logic tally_update;
    logic scan_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cfg_write;
    logic in_valid;
    logic div_done;
    logic upscale;
    logic last_now;
    logic group_end;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

@@ hdl/cmmr_if.sv @@
// ----------------------------------------------------------------------------
// cmmr_if
// Valid/ready stream channels: source cells in, run-length blocks out.
// ----------------------------------------------------------------------------
interface cmmr_cell_if;
  logic                             valid;
  logic                             ready;
  logic [cmmr_pkg::STATE_W-1:0]     cell_state;

  modport source (output valid, output cell_state, input ready);
  modport sink   (input valid, input cell_state, output ready);
endinterface

interface cmmr_block_if;
  logic                             valid;
  logic                             ready;
  logic [cmmr_pkg::STATE_W-1:0]     block_state;
  logic [cmmr_pkg::TGT_W-1:0]       repeat_count;
  logic                             last_of_map;

  modport source (output valid, output block_state, output repeat_count,
                  output last_of_map, input ready);
  modport sink   (input valid, input block_state, input repeat_count,
                  input last_of_map, output ready);
endinterface

@@ hdl/cmmr_datapath.sv @@
// ----------------------------------------------------------------------------
// cmmr_datapath
// Configuration registers, ratio divider, pass counters, state tally memory
// with argmax scan, and the output register.
// ----------------------------------------------------------------------------
module cmmr_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cmmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmmr_pkg::CFG_W-1:0]      cfg_data_i,
  input  cmmr_pkg::cmd_t                  cmd_i,
  output cmmr_pkg::status_t               status_o,
  cmmr_cell_if.sink                       in_if,
  cmmr_block_if.source                    out_if
);

  logic [cmmr_pkg::SRC_W-1:0]      src_cnt_q;
  logic [cmmr_pkg::TGT_W-1:0]      tgt_cnt_q;
  logic [cmmr_pkg::SRC_W-1:0]      src_eff;
  logic [cmmr_pkg::TGT_W-1:0]      tgt_eff;
  logic                            up_now;

  logic                            upscale_q;
  logic [cmmr_pkg::DIV_W:0]        div_rem_q;
  logic [cmmr_pkg::DIV_W-1:0]      div_quo_q;
  logic [cmmr_pkg::DIV_W-1:0]      div_den_q;
  logic [cmmr_pkg::DIV_CNT_W-1:0]  div_cnt_q;
  logic [cmmr_pkg::DIV_W:0]        rem_sh;

  logic [cmmr_pkg::SIDX_W-1:0]     src_idx_q;
  logic [cmmr_pkg::TIDX_W-1:0]     tgt_idx_q;
  logic [cmmr_pkg::FILL_W-1:0]     fill_q;
  logic                            last_q;
  logic                            last_now;
  logic                            group_end;

  logic [cmmr_pkg::MEM_AW-1:0]     cell_clamp;
  logic [cmmr_pkg::MEM_AW-1:0]     cell_q;

  logic [cmmr_pkg::TALLY_W-1:0]    tally_mem [cmmr_pkg::NUM_STATES];
  logic [cmmr_pkg::NUM_STATES-1:0] tally_vld_q;
  logic [cmmr_pkg::TALLY_W-1:0]    rd_data_q;
  logic                            rd_vld_q;
  logic [cmmr_pkg::MEM_AW-1:0]     rd_addr;
  logic [cmmr_pkg::MEM_AW-1:0]     rd_addr_q;
  logic                            rd_en;
  logic [cmmr_pkg::TALLY_W-1:0]    tally_rd;

  logic [cmmr_pkg::SCAN_W-1:0]     scan_idx_q;
  logic                            scan_pend_q;
  logic [cmmr_pkg::TALLY_W-1:0]    best_q;
  logic [cmmr_pkg::MEM_AW-1:0]     code_q;

  logic                            out_vld_q;
  logic [cmmr_pkg::STATE_W-1:0]    out_state_q;
  logic [cmmr_pkg::TGT_W-1:0]      out_rep_q;
  logic                            out_last_q;

  always_comb begin
    if (src_cnt_q == '0) begin
      src_eff = cmmr_pkg::SRC_W'(1);
    end else if (src_cnt_q > cmmr_pkg::SRC_W'(cmmr_pkg::MAX_SOURCE)) begin
      src_eff = cmmr_pkg::SRC_W'(cmmr_pkg::MAX_SOURCE);
    end else begin
      src_eff = src_cnt_q;
    end
    if (tgt_cnt_q == '0) begin
      tgt_eff = cmmr_pkg::TGT_W'(1);
    end else if (tgt_cnt_q > cmmr_pkg::TGT_W'(cmmr_pkg::MAX_TARGET)) begin
      tgt_eff = cmmr_pkg::TGT_W'(cmmr_pkg::MAX_TARGET);
    end else begin
      tgt_eff = tgt_cnt_q;
    end
  end

  assign up_now = (cmmr_pkg::SRC_W'(tgt_eff) >= src_eff);
  assign rem_sh = {div_rem_q[cmmr_pkg::DIV_W-1:0], div_quo_q[cmmr_pkg::DIV_W-1]};

  always_comb begin
    if ({1'b0, in_if.cell_state} >= (cmmr_pkg::STATE_W+1)'(cmmr_pkg::NUM_STATES)) begin
      cell_clamp = cmmr_pkg::MEM_AW'(cmmr_pkg::NUM_STATES - 1);
    end else begin
      cell_clamp = in_if.cell_state[cmmr_pkg::MEM_AW-1:0];
    end
  end

  assign last_now  = ((cmmr_pkg::SRC_W'(src_idx_q) + cmmr_pkg::SRC_W'(1)) >= src_eff);
  assign group_end = ((cmmr_pkg::TGT_W'(tgt_idx_q) + cmmr_pkg::TGT_W'(1)) < tgt_eff) &&
                     (({1'b0, fill_q} + (cmmr_pkg::FILL_W+1)'(1)) >= {1'b0, div_quo_q});

  assign rd_en    = cmd_i.accept ||
                    (cmd_i.scan_step &&
                     (scan_idx_q != cmmr_pkg::SCAN_W'(cmmr_pkg::NUM_STATES)));
  assign rd_addr  = cmd_i.scan_step ? scan_idx_q[cmmr_pkg::MEM_AW-1:0] : cell_clamp;
  assign tally_rd = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tally_update) begin
      tally_mem[cell_q] <= tally_rd + cmmr_pkg::TALLY_W'(1);
    end
    if (rd_en) begin
      rd_data_q <= tally_mem[rd_addr];
    end
    if (cmd_i.accept) begin
      cell_q <= cell_clamp;
    end
    if (cmd_i.emit) begin
      if (upscale_q) begin
        out_state_q <= cmmr_pkg::STATE_W'(cell_q);
        out_last_q  <= last_now;
        if (last_now) begin
          out_rep_q <= div_quo_q[cmmr_pkg::TGT_W-1:0] + div_rem_q[cmmr_pkg::TGT_W-1:0];
        end else begin
          out_rep_q <= div_quo_q[cmmr_pkg::TGT_W-1:0];
        end
      end else begin
        out_state_q <= cmmr_pkg::STATE_W'(code_q);
        out_rep_q   <= cmmr_pkg::TGT_W'(1);
        out_last_q  <= last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q   <= cmmr_pkg::SRC_W'(1);
      tgt_cnt_q   <= cmmr_pkg::TGT_W'(4640);
      upscale_q   <= 1'b0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      div_den_q   <= '0;
      div_cnt_q   <= '0;
      src_idx_q   <= '0;
      tgt_idx_q   <= '0;
      fill_q      <= '0;
      last_q      <= 1'b0;
      tally_vld_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_addr_q   <= '0;
      scan_idx_q  <= '0;
      scan_pend_q <= 1'b0;
      best_q      <= '0;
      code_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.div_start) begin
        upscale_q <= up_now;
        div_rem_q <= '0;
        div_quo_q <= up_now ? cmmr_pkg::DIV_W'(tgt_eff) : src_eff;
        div_den_q <= up_now ? src_eff : cmmr_pkg::DIV_W'(tgt_eff);
        div_cnt_q <= cmmr_pkg::DIV_CNT_W'(cmmr_pkg::DIV_W);
      end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
        if (rem_sh >= {1'b0, div_den_q}) begin
          div_rem_q <= rem_sh - {1'b0, div_den_q};
          div_quo_q <= {div_quo_q[cmmr_pkg::DIV_W-2:0], 1'b1};
        end else begin
          div_rem_q <= rem_sh;
          div_quo_q <= {div_quo_q[cmmr_pkg::DIV_W-2:0], 1'b0};
        end
        div_cnt_q <= div_cnt_q - cmmr_pkg::DIV_CNT_W'(1);
      end

      if (rd_en) begin
        rd_vld_q  <= tally_vld_q[rd_addr];
        rd_addr_q <= rd_addr;
      end

      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cmmr_pkg::cfg_reg_e'(cfg_idx_i))
          cmmr_pkg::REG_SOURCE_COUNT: src_cnt_q <= cfg_data_i;
          cmmr_pkg::REG_TARGET_COUNT: tgt_cnt_q <= cfg_data_i[cmmr_pkg::TGT_W-1:0];
          default: ;
        endcase
        src_idx_q   <= '0;
        tgt_idx_q   <= '0;
        fill_q      <= '0;
        tally_vld_q <= '0;
      end else begin
        if (cmd_i.tally_update) begin
          tally_vld_q[cell_q] <= 1'b1;
          fill_q      <= fill_q + cmmr_pkg::FILL_W'(1);
          last_q      <= last_now;
          if (!last_now) begin
            src_idx_q <= src_idx_q + cmmr_pkg::SIDX_W'(1);
          end
          scan_idx_q  <= '0;
          scan_pend_q <= 1'b0;
          best_q      <= '0;
          code_q      <= '0;
        end

        if (cmd_i.scan_step) begin
          if (scan_idx_q != cmmr_pkg::SCAN_W'(cmmr_pkg::NUM_STATES)) begin
            scan_idx_q <= scan_idx_q + cmmr_pkg::SCAN_W'(1);
          end
          scan_pend_q <= (scan_idx_q != cmmr_pkg::SCAN_W'(cmmr_pkg::NUM_STATES));
          if (scan_pend_q && (tally_rd >= best_q)) begin
            best_q <= tally_rd;
            code_q <= rd_addr_q;
          end
        end

        if (cmd_i.emit) begin
          if (upscale_q) begin
            if (last_now) begin
              src_idx_q <= '0;
              tgt_idx_q <= '0;
              fill_q    <= '0;
            end else begin
              src_idx_q <= src_idx_q + cmmr_pkg::SIDX_W'(1);
            end
          end else begin
            tally_vld_q <= '0;
            fill_q      <= '0;
            if (last_q) begin
              src_idx_q <= '0;
              tgt_idx_q <= '0;
            end else begin
              tgt_idx_q <= tgt_idx_q + cmmr_pkg::TIDX_W'(1);
            end
          end
        end
      end
    end
  end

  assign in_if.ready         = cmd_i.in_ready;
  assign out_if.valid        = out_vld_q;
  assign out_if.block_state  = out_state_q;
  assign out_if.repeat_count = out_rep_q;
  assign out_if.last_of_map  = out_last_q;

  assign status_o.cfg_write = cfg_we_i;
  assign status_o.in_valid  = in_if.valid;
  assign status_o.div_done  = (div_cnt_q == '0);
  assign status_o.upscale   = upscale_q;
  assign status_o.last_now  = last_now;
  assign status_o.group_end = group_end;
  assign status_o.scan_done = (scan_idx_q == cmmr_pkg::SCAN_W'(cmmr_pkg::NUM_STATES)) &&
                              !scan_pend_q;
  assign status_o.out_free  = !out_vld_q || out_if.ready;

  a_cfg_restarts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (src_idx_q == '0) && (tgt_idx_q == '0) && (fill_q == '0) &&
                 (tally_vld_q == '0))
    else $error("register write did not restart the pass");

  a_src_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmmr_pkg::SRC_W'(src_idx_q) < src_eff))
    else $error("source index ran past the source count");

  a_tgt_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmmr_pkg::TGT_W'(tgt_idx_q) < tgt_eff))
    else $error("target index ran past the target count");

endmodule

@@ hdl/cmmr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cmmr_ctrl
// Sequencer: ratio division after reset and register writes, cell transfer,
// tally update, argmax scan and result emission.
// ----------------------------------------------------------------------------
module cmmr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmmr_pkg::status_t  status_i,
  output cmmr_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_DIV_INIT,
    S_DIV_RUN,
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   rdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_DIV_INIT;
      rdy_q   <= 1'b0;
    end else if (status_i.cfg_write) begin
      state_q <= S_DIV_INIT;
      rdy_q   <= 1'b0;
    end else begin
      case (state_q)
        S_DIV_INIT: begin
          state_q <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          if (status_i.div_done) begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        S_IDLE: begin
          if (rdy_q && status_i.in_valid) begin
            rdy_q   <= 1'b0;
            state_q <= status_i.upscale ? S_EMIT : S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (status_i.last_now || status_i.group_end) begin
            state_q <= S_SCAN;
          end else begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        S_SCAN: begin
          if (status_i.scan_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= S_DIV_INIT;
          rdy_q   <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.in_ready     = rdy_q;
  assign cmd_o.accept       = rdy_q && status_i.in_valid;
  assign cmd_o.div_start    = (state_q == S_DIV_INIT);
  assign cmd_o.div_step     = (state_q == S_DIV_RUN);
  assign cmd_o.tally_update = (state_q == S_UPDATE);
  assign cmd_o.scan_step    = (state_q == S_SCAN);
  assign cmd_o.emit         = (state_q == S_EMIT) && status_i.out_free;

  a_accept_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> status_i.div_done)
    else $error("cell transferred before the ratio was ready");

endmodule

@@ hdl/cluster_map_mode_resampler_unit.sv @@
// ----------------------------------------------------------------------------
// cluster_map_mode_resampler_unit
// Resamples cell-state codes to display blocks as run-length results.
// ----------------------------------------------------------------------------
// After reset and after every register write a 21-step divider works out the
// resampling ratio before the first cell transfer. Up-scaling gives one
// result per cell. Down-scaling reads the tally memory for each cell and then
// writes it; a cell that closes a group is followed by a sequential argmax over
// the tally memory and then the loading of the output register. A result
// waiting in the output register stalls the block only when the next result
// is due.
module cluster_map_mode_resampler_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cmmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmmr_pkg::CFG_W-1:0]      cfg_data_i,
  cmmr_cell_if.sink                       in_if,
  cmmr_block_if.source                    out_if
);

  cmmr_pkg::cmd_t    cmd;
  cmmr_pkg::status_t status;

  cmmr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cmmr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_if      (in_if),
    .out_if     (out_if)
  );

endmodule
